/* hdl/crfe_pkg.sv */
// ----------------------------------------------------------------------------
// crfe_pkg: shared definitions for the clipped rectangle fill engine
// widths, reset values, action and register codes, clip result type
// ----------------------------------------------------------------------------
`default_nettype none

package crfe_pkg;

  // fixed widths
  localparam int unsigned DIM_BITS      = 12;
  localparam int unsigned ADDR_BITS     = 32;
  localparam int unsigned STRIDE_BITS   = 16;
  localparam int unsigned ACTION_BITS   = 2;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned PART_BITS     = 2;
  localparam int unsigned NUM_PARTS     = 4;

  // defaults for the top level parameters
  localparam int unsigned COORD_BITS_DEF  = 16;
  localparam int unsigned COLOUR_BITS_DEF = 32;

  // register reset values
  localparam logic [DIM_BITS-1:0]    CANVAS_W_RST = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0]    CANVAS_H_RST = DIM_BITS'(400);
  localparam logic [STRIDE_BITS-1:0] STRIDE_RST   = STRIDE_BITS'(640);

  // last frame part (right edge)
  localparam logic [PART_BITS-1:0] PART_LAST = PART_BITS'(NUM_PARTS - 1);

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_TICK  = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_FRAME = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CANVAS_PRESENT = 3'd0,
    CFG_FRAME_BASE     = 3'd1,
    CFG_CANVAS_WIDTH   = 3'd2,
    CFG_CANVAS_HEIGHT  = 3'd3,
    CFG_ROW_STRIDE     = 3'd4
  } cfg_idx_e;

  // one clipped rectangle, fields valid only when ok is set
  typedef struct packed {
    logic                ok;
    logic [DIM_BITS-1:0] x;
    logic [DIM_BITS-1:0] y;
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
  } clip_res_t;

endpackage

`default_nettype wire

/* hdl/crfe_if.sv */
// ----------------------------------------------------------------------------
// crfe channel interfaces
// command channel into the engine and pixel write channel out of it
// ----------------------------------------------------------------------------
`default_nettype none

interface crfe_cmd_if #(
  parameter int unsigned COORD_BITS  = crfe_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOUR_BITS = crfe_pkg::COLOUR_BITS_DEF
) ();
  import crfe_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [ACTION_BITS-1:0]        action;
  logic signed [COORD_BITS-1:0]  rect_x;
  logic signed [COORD_BITS-1:0]  rect_y;
  logic signed [COORD_BITS-1:0]  rect_w;
  logic signed [COORD_BITS-1:0]  rect_h;
  logic signed [COORD_BITS-1:0]  edge_thickness;
  logic [COLOUR_BITS-1:0]        fill_colour;

  modport source (
    output valid, action, rect_x, rect_y, rect_w, rect_h, edge_thickness, fill_colour,
    input  ready
  );
  modport sink (
    input  valid, action, rect_x, rect_y, rect_w, rect_h, edge_thickness, fill_colour,
    output ready
  );
endinterface

interface crfe_pix_if #(
  parameter int unsigned COLOUR_BITS = crfe_pkg::COLOUR_BITS_DEF
) ();
  import crfe_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ADDR_BITS-1:0]   pixel_address;
  logic [COLOUR_BITS-1:0] pixel_value;
  logic                   last_of_command;

  modport source (
    output valid, pixel_address, pixel_value, last_of_command,
    input  ready
  );
  modport sink (
    input  valid, pixel_address, pixel_value, last_of_command,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/crfe_clip.sv */
// ----------------------------------------------------------------------------
// crfe_clip: clip one signed rectangle to the canvas
// negative origins shorten the size, far edges are cut at the canvas size
// ----------------------------------------------------------------------------
`default_nettype none

module crfe_clip #(
  parameter int unsigned CW = 20
) (
  input  logic signed [CW-1:0]            x_i,
  input  logic signed [CW-1:0]            y_i,
  input  logic signed [CW-1:0]            w_i,
  input  logic signed [CW-1:0]            h_i,
  input  logic [crfe_pkg::DIM_BITS-1:0]   canvas_w_i,
  input  logic [crfe_pkg::DIM_BITS-1:0]   canvas_h_i,
  output crfe_pkg::clip_res_t             res_o
);
  import crfe_pkg::*;

  logic signed [CW-1:0] cw_s, ch_s;
  logic signed [CW-1:0] x_end, y_end;
  logic signed [CW-1:0] x_lo, y_lo;
  logic signed [CW-1:0] x_hi, y_hi;
  logic signed [CW-1:0] w_c, h_c;

  assign cw_s = $signed({{(CW-DIM_BITS){1'b0}}, canvas_w_i});
  assign ch_s = $signed({{(CW-DIM_BITS){1'b0}}, canvas_h_i});

  // far edges, then clamp both ends
  assign x_end = x_i + w_i;
  assign y_end = y_i + h_i;
  assign x_lo  = (x_i < 0) ? '0 : x_i;
  assign y_lo  = (y_i < 0) ? '0 : y_i;
  assign x_hi  = (x_end > cw_s) ? cw_s : x_end;
  assign y_hi  = (y_end > ch_s) ? ch_s : y_end;
  assign w_c   = x_hi - x_lo;
  assign h_c   = y_hi - y_lo;

  // a nonempty result lies inside the canvas, so the low bits suffice
  assign res_o.ok = (w_c > 0) && (h_c > 0);
  assign res_o.x  = x_lo[DIM_BITS-1:0];
  assign res_o.y  = y_lo[DIM_BITS-1:0];
  assign res_o.w  = w_c[DIM_BITS-1:0];
  assign res_o.h  = h_c[DIM_BITS-1:0];

endmodule

`default_nettype wire

/* hdl/clipped_rect_fill_engine_unit.sv */
// ----------------------------------------------------------------------------
// clipped_rect_fill_engine_unit: framebuffer rectangle and frame filler
// clips fill and frame commands to the canvas and emits one pixel write per tick
// ----------------------------------------------------------------------------
// usage
//   cmd_i carries items: a fill or frame command loads the walker, a tick item
//   asks for the next pixel write. commands that arrive while a rectangle is
//   still being walked are dropped; ticks while idle give nothing
//   pix_o carries pixel writes (address, colour, last of command flag)
//   cfg_* writes the canvas registers, one per cycle, no read-back
// timing
//   an accepted item is held in the input register; a tick's pixel write then
//   goes into the output register, which drives pix_o
//   one item per clock sustained while pix_o is not held off; the path that sets
//   the clock is the four parallel clippers, the first nonempty part pick, the row
//   times stride multiply and the base address add
// reset
//   walker idle, output empty, canvas absent, 640 by 400 with stride 640
// stalls
//   when pix_o is held off the output register keeps its write and a tick in
//   the input register waits; commands and idle ticks still drain, and the
//   input register refills in the same cycle it empties
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_rect_fill_engine_unit #(
  parameter int unsigned COORD_BITS  = crfe_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOUR_BITS = crfe_pkg::COLOUR_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [crfe_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [crfe_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  crfe_cmd_if.sink                           cmd_i,
  crfe_pix_if.source                         pix_o
);
  import crfe_pkg::*;

  // coordinate width with room for x + w - t and the canvas size
  localparam int unsigned CW = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 4;
  localparam int unsigned PROD_BITS = DIM_BITS + STRIDE_BITS;

  // configuration registers
  logic                   canvas_present_q;
  logic [ADDR_BITS-1:0]   frame_base_q;
  logic [DIM_BITS-1:0]    canvas_width_q;
  logic [DIM_BITS-1:0]    canvas_height_q;
  logic [STRIDE_BITS-1:0] row_stride_q;

  // input register
  logic                         s1_valid_q;
  logic [ACTION_BITS-1:0]       s1_action_q;
  logic signed [COORD_BITS-1:0] s1_x_q, s1_y_q, s1_w_q, s1_h_q, s1_t_q;
  logic [COLOUR_BITS-1:0]       s1_colour_q;

  // walker state
  logic                         busy_q, busy_d;
  logic                         frame_mode_q, frame_mode_d;
  logic [PART_BITS-1:0]         frame_part_q, frame_part_d;
  logic signed [COORD_BITS-1:0] sv_x_q, sv_y_q, sv_w_q, sv_h_q, sv_t_q;
  logic [COLOUR_BITS-1:0]       sv_colour_q;
  logic [DIM_BITS-1:0]          clip_left_q, clip_left_d;
  logic [DIM_BITS-1:0]          clip_width_q, clip_width_d;
  logic [DIM_BITS-1:0]          rows_left_q, rows_left_d;
  logic [DIM_BITS-1:0]          column_index_q, column_index_d;
  logic [ADDR_BITS-1:0]         row_start_q, row_start_d;

  // output register
  logic                   out_valid_q;
  logic [ADDR_BITS-1:0]   out_addr_q;
  logic [COLOUR_BITS-1:0] out_value_q;
  logic                   out_last_q;

  // handshake
  logic is_tick, is_fill, is_frame, is_cmd;
  logic s1_emits, out_free, s1_adv, in_take;

  assign is_tick  = (s1_action_q == ACT_TICK);
  assign is_fill  = (s1_action_q == ACT_FILL);
  assign is_frame = (s1_action_q == ACT_FRAME);
  assign is_cmd   = is_fill || is_frame;

  assign s1_emits = is_tick && busy_q;
  assign out_free = !out_valid_q || pix_o.ready;
  assign s1_adv   = s1_valid_q && (!s1_emits || out_free);
  assign in_take  = cmd_i.valid && cmd_i.ready;

  assign cmd_i.ready = !s1_valid_q || s1_adv;

  // clip sources: the new command, or the saved one while walking a frame
  logic signed [CW-1:0] src_x, src_y, src_w, src_h, src_t;
  logic signed [CW-1:0] p0_h, p1_y, p3_x;

  assign src_x = is_cmd ? CW'(s1_x_q) : CW'(sv_x_q);
  assign src_y = is_cmd ? CW'(s1_y_q) : CW'(sv_y_q);
  assign src_w = is_cmd ? CW'(s1_w_q) : CW'(sv_w_q);
  assign src_h = is_cmd ? CW'(s1_h_q) : CW'(sv_h_q);
  assign src_t = is_cmd ? CW'(s1_t_q) : CW'(sv_t_q);

  // part zero doubles as the plain fill rectangle
  assign p0_h = is_fill ? src_h : src_t;
  assign p1_y = src_y + src_h - src_t;
  assign p3_x = src_x + src_w - src_t;

  clip_res_t clip_res [NUM_PARTS];

  // top, bottom, left, right
  crfe_clip #(.CW(CW)) u_clip_top (
    .x_i(src_x), .y_i(src_y), .w_i(src_w), .h_i(p0_h),
    .canvas_w_i(canvas_width_q), .canvas_h_i(canvas_height_q), .res_o(clip_res[0])
  );
  crfe_clip #(.CW(CW)) u_clip_bottom (
    .x_i(src_x), .y_i(p1_y), .w_i(src_w), .h_i(src_t),
    .canvas_w_i(canvas_width_q), .canvas_h_i(canvas_height_q), .res_o(clip_res[1])
  );
  crfe_clip #(.CW(CW)) u_clip_left (
    .x_i(src_x), .y_i(src_y), .w_i(src_t), .h_i(src_h),
    .canvas_w_i(canvas_width_q), .canvas_h_i(canvas_height_q), .res_o(clip_res[2])
  );
  crfe_clip #(.CW(CW)) u_clip_right (
    .x_i(p3_x), .y_i(src_y), .w_i(src_t), .h_i(src_h),
    .canvas_w_i(canvas_width_q), .canvas_h_i(canvas_height_q), .res_o(clip_res[3])
  );

  // first nonempty part among those still allowed
  logic [NUM_PARTS-1:0] allow, cand;
  logic                 sel_found;
  logic [PART_BITS-1:0] sel_idx;
  clip_res_t            sel;
  logic [PROD_BITS-1:0] sel_prod;
  logic [ADDR_BITS-1:0] load_addr;

  always_comb begin
    sel_found = 1'b0;
    sel_idx   = '0;
    for (int p = 0; p < NUM_PARTS; p++) begin
      if (is_fill) begin
        allow[p] = (p == 0);
      end else if (is_frame) begin
        allow[p] = 1'b1;
      end else begin
        allow[p] = (PART_BITS'(p) > frame_part_q);
      end
      cand[p] = allow[p] && clip_res[p].ok && canvas_present_q;
    end
    for (int p = NUM_PARTS - 1; p >= 0; p--) begin
      if (cand[p]) begin
        sel_found = 1'b1;
        sel_idx   = PART_BITS'(p);
      end
    end
  end

  assign sel       = clip_res[sel_idx];
  assign sel_prod  = sel.y * row_stride_q;
  assign load_addr = frame_base_q + ADDR_BITS'(sel_prod);

  // pixel walk
  logic [ADDR_BITS-1:0] tick_addr;
  logic [DIM_BITS-1:0]  col_inc, rows_dec;
  logic                 row_done, part_done, next_part, tick_last, frame_ok;

  assign tick_addr = row_start_q + ADDR_BITS'(clip_left_q) + ADDR_BITS'(column_index_q);
  assign col_inc   = column_index_q + 1'b1;
  assign rows_dec  = rows_left_q - 1'b1;
  assign row_done  = (col_inc >= clip_width_q);
  assign part_done = row_done && (rows_dec == '0);
  assign next_part = frame_mode_q && (frame_part_q != PART_LAST) && sel_found;
  assign tick_last = part_done && !next_part;
  assign frame_ok  = is_fill || ((s1_t_q > 0) && (s1_w_q > 0) && (s1_h_q > 0));

  always_comb begin
    busy_d         = busy_q;
    frame_mode_d   = frame_mode_q;
    frame_part_d   = frame_part_q;
    clip_left_d    = clip_left_q;
    clip_width_d   = clip_width_q;
    rows_left_d    = rows_left_q;
    column_index_d = column_index_q;
    row_start_d    = row_start_q;
    if (s1_adv && is_cmd && !busy_q) begin
      frame_mode_d = is_frame;
      frame_part_d = '0;
      busy_d       = frame_ok && sel_found;
      if (frame_ok && sel_found) begin
        frame_part_d   = sel_idx;
        clip_left_d    = sel.x;
        clip_width_d   = sel.w;
        rows_left_d    = sel.h;
        column_index_d = '0;
        row_start_d    = load_addr;
      end
    end else if (s1_adv && s1_emits) begin
      column_index_d = col_inc;
      if (row_done) begin
        column_index_d = '0;
        rows_left_d    = rows_dec;
        row_start_d    = row_start_q + ADDR_BITS'(row_stride_q);
        if (part_done) begin
          if (next_part) begin
            // move on to the next nonempty frame part
            frame_part_d   = sel_idx;
            clip_left_d    = sel.x;
            clip_width_d   = sel.w;
            rows_left_d    = sel.h;
            row_start_d    = load_addr;
          end else begin
            busy_d = 1'b0;
          end
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_present_q <= 1'b0;
      frame_base_q     <= '0;
      canvas_width_q   <= CANVAS_W_RST;
      canvas_height_q  <= CANVAS_H_RST;
      row_stride_q     <= STRIDE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CANVAS_PRESENT: canvas_present_q <= cfg_wdata_i[0];
        CFG_FRAME_BASE:     frame_base_q     <= cfg_wdata_i[ADDR_BITS-1:0];
        CFG_CANVAS_WIDTH:   canvas_width_q   <= cfg_wdata_i[DIM_BITS-1:0];
        CFG_CANVAS_HEIGHT:  canvas_height_q  <= cfg_wdata_i[DIM_BITS-1:0];
        CFG_ROW_STRIDE:     row_stride_q     <= cfg_wdata_i[STRIDE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      busy_q       <= 1'b0;
      frame_mode_q <= 1'b0;
      frame_part_q <= '0;
    end else begin
      if (cmd_i.ready) begin
        s1_valid_q <= cmd_i.valid;
      end
      if (s1_adv && s1_emits) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
      busy_q       <= busy_d;
      frame_mode_q <= frame_mode_d;
      frame_part_q <= frame_part_d;
    end
  end

  // payload, walker counters and saved command
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_action_q <= cmd_i.action;
      s1_x_q      <= cmd_i.rect_x;
      s1_y_q      <= cmd_i.rect_y;
      s1_w_q      <= cmd_i.rect_w;
      s1_h_q      <= cmd_i.rect_h;
      s1_t_q      <= cmd_i.edge_thickness;
      s1_colour_q <= cmd_i.fill_colour;
    end
    if (s1_adv && is_cmd && !busy_q) begin
      sv_x_q      <= s1_x_q;
      sv_y_q      <= s1_y_q;
      sv_w_q      <= s1_w_q;
      sv_h_q      <= s1_h_q;
      sv_t_q      <= s1_t_q;
      sv_colour_q <= s1_colour_q;
    end
    if (s1_adv && s1_emits) begin
      out_addr_q  <= tick_addr;
      out_value_q <= sv_colour_q;
      out_last_q  <= tick_last;
    end
    clip_left_q    <= clip_left_d;
    clip_width_q   <= clip_width_d;
    rows_left_q    <= rows_left_d;
    column_index_q <= column_index_d;
    row_start_q    <= row_start_d;
  end

  assign pix_o.valid           = out_valid_q;
  assign pix_o.pixel_address   = out_addr_q;
  assign pix_o.pixel_value     = out_value_q;
  assign pix_o.last_of_command = out_last_q;

  // a walked rectangle is never empty
  a_busy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (clip_width_q != '0) && (rows_left_q != '0) &&
               (column_index_q < clip_width_q))
    else $error("walker busy on an empty rectangle");

  // the flagged last write ends the command
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_emits && tick_last) |=> !busy_q)
    else $error("engine still busy after last write");

  // without a canvas no command starts the walker
  a_no_canvas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && is_cmd && !busy_q && !canvas_present_q) |=> !busy_q)
    else $error("command started with canvas absent");

  // a waiting write is not replaced while the receiver stalls
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pix_o.ready) |-> !(s1_adv && s1_emits))
    else $error("pending pixel write overwritten");

endmodule

`default_nettype wire

/* sim/clipped_rect_fill_engine_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clipped_rect_fill_engine_unit_tb: self-checking bench for the fill engine
// feeds fill, frame and tick items through the command channel, predicts
// every pixel write from its own copy of the walker and checks the write
// channel field by field under random stalls on both sides
// ----------------------------------------------------------------------------

module clipped_rect_fill_engine_unit_tb;
  import crfe_pkg::*;

  localparam int unsigned XY_BITS  = COORD_BITS_DEF;
  localparam int unsigned COL_BITS = COLOUR_BITS_DEF;

  // the one action code the engine ignores
  localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

  localparam int HOLD_CYCLES   = 400;   // long write-side hold-off
  localparam int QUIET_LIMIT   = 5000;  // cycles with no item moving on either side
  localparam int SETTLE_CYCLES = 6;     // input register plus output register, with margin
  localparam int DRAIN_TICKS   = 64;    // ticks added per round while a walk is unfinished

  typedef struct {
    logic [ACTION_BITS-1:0]    action;
    logic signed [XY_BITS-1:0] x;
    logic signed [XY_BITS-1:0] y;
    logic signed [XY_BITS-1:0] w;
    logic signed [XY_BITS-1:0] h;
    logic signed [XY_BITS-1:0] thick;
    logic [COL_BITS-1:0]       colour;
  } cmd_item_t;

  typedef struct {
    logic [ADDR_BITS-1:0] addr;
    logic [COL_BITS-1:0]  value;
    logic                 last;
  } pix_write_t;

  // clock, reset, register port
  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  crfe_cmd_if #(.COORD_BITS(XY_BITS), .COLOUR_BITS(COL_BITS)) cmd_bus ();
  crfe_pix_if #(.COLOUR_BITS(COL_BITS)) pix_bus ();

  clipped_rect_fill_engine_unit #(
    .COORD_BITS  (XY_BITS),
    .COLOUR_BITS (COL_BITS)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd_bus),
    .pix_o       (pix_bus)
  );

  // stimulus and scoreboard state
  cmd_item_t  cmd_backlog[$];   // items waiting for the driver
  pix_write_t owed_writes[$];   // pixel writes predicted but not yet seen
  cmd_item_t  on_bus;           // item currently offered on the command channel
  pix_write_t due_write;
  int         queued_count;
  int         taken_count;
  int         fail_count;
  int         quiet_cycles;
  int         src_idle_pct;
  int         snk_idle_pct;
  int         hold_left;
  logic       hold_kick;

  // predictor copy of the canvas registers
  logic                   canvas_on;
  logic [ADDR_BITS-1:0]   base_addr;
  logic [DIM_BITS-1:0]    canvas_w;
  logic [DIM_BITS-1:0]    canvas_h;
  logic [STRIDE_BITS-1:0] stride;

  // predictor copy of the walker
  logic                  walking;
  logic                  framing;
  logic [PART_BITS-1:0]  part;
  int                    sx, sy, sw, sh, st;
  logic [COL_BITS-1:0]   colour_q;
  logic [DIM_BITS-1:0]   left_col;
  logic [DIM_BITS-1:0]   span_w;
  logic [DIM_BITS-1:0]   rows_to_go;
  logic [DIM_BITS-1:0]   col;
  logic [ADDR_BITS-1:0]  row_addr;

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // clip one rectangle to the canvas and load the walker; 0 when nothing shows
  function automatic logic clip_and_load(int x, int y, int w, int h);
    int cw;
    int ch;
    cw = int'(canvas_w);
    ch = int'(canvas_h);
    if (!canvas_on) return 1'b0;
    // a negative origin eats into the size
    if (x < 0) begin
      w = w + x;
      x = 0;
    end
    if (y < 0) begin
      h = h + y;
      y = 0;
    end
    // far edges cut at the canvas border
    if (x + w > cw) w = cw - x;
    if (y + h > ch) h = ch - y;
    if (w <= 0 || h <= 0) return 1'b0;
    left_col   = x[DIM_BITS-1:0];
    span_w     = w[DIM_BITS-1:0];
    rows_to_go = h[DIM_BITS-1:0];
    col        = '0;
    // base sampled here only, stride also applied live as rows advance
    row_addr   = base_addr + ADDR_BITS'(y) * ADDR_BITS'(stride);
    return 1'b1;
  endfunction

  // frame parts in order: top, bottom, left, right
  function automatic logic load_frame_part(int p);
    case (p)
      0:       return clip_and_load(sx, sy, sw, st);
      1:       return clip_and_load(sx, sy + sh - st, sw, st);
      2:       return clip_and_load(sx, sy, st, sh);
      default: return clip_and_load(sx + sw - st, sy, st, sh);
    endcase
  endfunction

  // first frame part from p on that clips to something; empty parts skipped
  function automatic logic next_frame_part(int p);
    while (p < int'(NUM_PARTS)) begin
      if (load_frame_part(p)) begin
        part = PART_BITS'(p);
        return 1'b1;
      end
      p++;
    end
    return 1'b0;
  endfunction

  // apply one accepted item; a tick on a busy walker owes one pixel write
  function automatic void step_engine(cmd_item_t it);
    pix_write_t px;
    if (it.action == ACT_FILL || it.action == ACT_FRAME) begin
      // commands while busy are dropped without touching anything
      if (walking) return;
      sx       = int'(it.x);
      sy       = int'(it.y);
      sw       = int'(it.w);
      sh       = int'(it.h);
      st       = int'(it.thick);
      colour_q = it.colour;
      part     = '0;
      if (it.action == ACT_FILL) begin
        framing = 1'b0;
        walking = clip_and_load(sx, sy, sw, sh);
      end else begin
        framing = 1'b1;
        // nonpositive thickness or size draws nothing
        if (st <= 0 || sw <= 0 || sh <= 0) walking = 1'b0;
        else walking = next_frame_part(0);
      end
      return;
    end
    // unused action and ticks while idle give nothing
    if (it.action != ACT_TICK || !walking) return;

    px.addr  = row_addr + ADDR_BITS'(left_col) + ADDR_BITS'(col);
    px.value = colour_q;
    px.last  = 1'b0;
    col      = col + 1'b1;
    if (col >= span_w) begin
      col        = '0;
      rows_to_go = rows_to_go - 1'b1;
      row_addr   = row_addr + ADDR_BITS'(stride);
      if (rows_to_go == '0) begin
        // end of a rectangle: on to the next frame part or done
        if (!(framing && part != PART_LAST && next_frame_part(int'(part) + 1))) begin
          px.last = 1'b1;
          walking = 1'b0;
        end
      end
    end
    owed_writes.push_back(px);
  endfunction

  // --------------------------------------------------------------------------
  // clock, driver, monitor, hold-off and watchdog
  // --------------------------------------------------------------------------

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // command driver: holds an item until taken, predicts at the accepting edge
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        step_engine(on_bus);
        taken_count++;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          on_bus                 = cmd_backlog.pop_front();
          cmd_bus.valid          <= 1'b1;
          cmd_bus.action         <= on_bus.action;
          cmd_bus.rect_x         <= on_bus.x;
          cmd_bus.rect_y         <= on_bus.y;
          cmd_bus.rect_w         <= on_bus.w;
          cmd_bus.rect_h         <= on_bus.h;
          cmd_bus.edge_thickness <= on_bus.thick;
          cmd_bus.fill_colour    <= on_bus.colour;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // write channel monitor: every pixel write against the oldest prediction
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pix_bus.ready <= 1'b0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        if (owed_writes.size() == 0) begin
          $error("pixel write with none expected: pixel_address %h", pix_bus.pixel_address);
          fail_count++;
        end else begin
          due_write = owed_writes.pop_front();
          if (pix_bus.pixel_address !== due_write.addr) begin
            $error("pixel_address expected %h actual %h", due_write.addr,
                   pix_bus.pixel_address);
            fail_count++;
          end
          if (pix_bus.pixel_value !== due_write.value) begin
            $error("pixel_value expected %h actual %h", due_write.value, pix_bus.pixel_value);
            fail_count++;
          end
          if (pix_bus.last_of_command !== due_write.last) begin
            $error("last_of_command expected %b actual %b", due_write.last,
                   pix_bus.last_of_command);
            fail_count++;
          end
        end
      end
      pix_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // long write-side hold-off, started by a one-cycle kick
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog: too long without an item moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_bus.valid && cmd_bus.ready) || (pix_bus.valid && pix_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_CANVAS_PRESENT: canvas_on = data[0];
      CFG_FRAME_BASE:     base_addr = data[ADDR_BITS-1:0];
      CFG_CANVAS_WIDTH:   canvas_w  = data[DIM_BITS-1:0];
      CFG_CANVAS_HEIGHT:  canvas_h  = data[DIM_BITS-1:0];
      CFG_ROW_STRIDE:     stride    = data[STRIDE_BITS-1:0];
      default: ;
    endcase
  endtask

  // all five registers, only ever called with the engine idle
  task automatic program_canvas(logic present, logic [ADDR_BITS-1:0] base_val,
                                int w, int h, int s);
    write_reg(CFG_CANVAS_PRESENT, CFG_DATA_BITS'(present));
    write_reg(CFG_FRAME_BASE, CFG_DATA_BITS'(base_val));
    write_reg(CFG_CANVAS_WIDTH, CFG_DATA_BITS'(w));
    write_reg(CFG_CANVAS_HEIGHT, CFG_DATA_BITS'(h));
    write_reg(CFG_ROW_STRIDE, CFG_DATA_BITS'(s));
    cfg_we <= 1'b0;
  endtask

  task automatic queue_cmd(logic [ACTION_BITS-1:0] action, int x, int y, int w, int h,
                           int thick, logic [COL_BITS-1:0] colour);
    cmd_item_t it;
    it.action = action;
    it.x      = XY_BITS'(x);
    it.y      = XY_BITS'(y);
    it.w      = XY_BITS'(w);
    it.h      = XY_BITS'(h);
    it.thick  = XY_BITS'(thick);
    it.colour = colour;
    cmd_backlog.push_back(it);
    queued_count++;
  endtask

  // ticks carry random junk in the unused fields
  task automatic push_ticks(int n);
    repeat (n) begin
      queue_cmd(ACT_TICK, int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                int'($urandom), $urandom);
    end
  endtask

  // sizes stay small unless the canvas itself is small, so every walk is short
  function automatic cmd_item_t make_command(logic wild);
    cmd_item_t it;
    int        reach;
    it.action = $urandom_range(1) ? ACT_FRAME : ACT_FILL;
    it.colour = $urandom;
    if (wild && $urandom_range(3) == 0) begin
      it.x     = XY_BITS'($urandom);
      it.y     = XY_BITS'($urandom);
      it.w     = XY_BITS'($urandom);
      it.h     = XY_BITS'($urandom);
      it.thick = XY_BITS'($urandom);
    end else begin
      reach    = (canvas_w < 32) ? 28 : 10;
      // hug either the near or the far canvas border
      it.x     = XY_BITS'($urandom_range(1) ? int'($urandom_range(12)) - 6
                                             : int'(canvas_w) - int'($urandom_range(8)));
      it.y     = XY_BITS'($urandom_range(1) ? int'($urandom_range(12)) - 6
                                             : int'(canvas_h) - int'($urandom_range(8)));
      it.w     = XY_BITS'(int'($urandom_range(reach + 2)) - 2);
      it.h     = XY_BITS'(int'($urandom_range(reach + 2)) - 2);
      it.thick = XY_BITS'(int'($urandom_range(5)) - 1);
    end
    return it;
  endfunction

  // mostly a command plus about enough ticks to walk it, with stray items mixed in
  task automatic random_burst(int n, logic wild);
    cmd_item_t it;
    int        made;
    int        roll;
    longint    area;
    int        ticks;
    made = 0;
    while (made < n) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        it = make_command(wild);
        cmd_backlog.push_back(it);
        queued_count++;
        if (it.action == ACT_FRAME)
          area = (it.thick > 0) ? 2 * longint'(it.thick) * (longint'(it.w) + longint'(it.h)) : 0;
        else
          area = (it.w > 0 && it.h > 0) ? longint'(it.w) * longint'(it.h) : 0;
        if (area < 0) area = 2;
        if (area > 48) area = 48;
        // a few walks are cut short so later commands land on a busy engine
        ticks = (roll < 10) ? int'(area) / 2 : int'(area) + int'($urandom_range(2));
        push_ticks(ticks);
        made += 1 + ticks;
      end else if (roll < 82) begin
        ticks = $urandom_range(1, 6);
        push_ticks(ticks);
        made += ticks;
      end else if (roll < 94) begin
        it = make_command(wild);
        cmd_backlog.push_back(it);
        queued_count++;
        made++;
      end else begin
        queue_cmd(ACT_UNUSED, int'($urandom), int'($urandom), int'($urandom),
                  int'($urandom), int'($urandom), $urandom);
      end
    end
  endtask

  // wait until every item is taken and every write seen, then finish any
  // walk still in progress with extra ticks so the engine is truly idle
  task automatic settle();
    logic done;
    done = 1'b0;
    while (!done) begin
      while (taken_count != queued_count || owed_writes.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (walking) push_ticks(DRAIN_TICKS);
      else done = 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_wdata              = '0;
    hold_kick              = 1'b0;
    cmd_bus.valid          = 1'b0;
    cmd_bus.action         = ACT_TICK;
    cmd_bus.rect_x         = '0;
    cmd_bus.rect_y         = '0;
    cmd_bus.rect_w         = '0;
    cmd_bus.rect_h         = '0;
    cmd_bus.edge_thickness = '0;
    cmd_bus.fill_colour    = '0;
    pix_bus.ready          = 1'b0;
    queued_count           = 0;
    taken_count            = 0;
    fail_count             = 0;
    quiet_cycles           = 0;
    // register and walker state as after reset
    canvas_on  = 1'b0;
    base_addr  = '0;
    canvas_w   = CANVAS_W_RST;
    canvas_h   = CANVAS_H_RST;
    stride     = STRIDE_RST;
    walking    = 1'b0;
    framing    = 1'b0;
    part       = '0;
    sx = 0; sy = 0; sw = 0; sh = 0; st = 0;
    colour_q   = '0;
    left_col   = '0;
    span_w     = '0;
    rows_to_go = '0;
    col        = '0;
    row_addr   = '0;
    // sender idles lightly, receiver heavily
    src_idle_pct = 36;
    snk_idle_pct = 78;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // canvas absent after reset: nothing drawn
    queue_cmd(ACT_FILL, 10, 10, 4, 4, 0, 32'h1234_5678);
    push_ticks(1);
    settle();

    // small canvas for the directed part
    program_canvas(1'b1, 32'h1000_0000, 16, 12, 20);
    // negative origin shortens to 2 by 2; command while busy dropped;
    // unused action ignored; tick while idle gives nothing
    queue_cmd(ACT_FILL, -1, -1, 3, 3, 0, 32'hFFFF_FFFF);
    queue_cmd(ACT_FILL, 0, 0, 5, 5, 0, 32'h0BAD_0BAD);
    queue_cmd(ACT_UNUSED, 1, 1, 1, 1, 1, 32'h0);
    push_ticks(5);
    // far corner clipped to a single pixel
    queue_cmd(ACT_FILL, 15, 11, 5, 5, 0, 32'h0000_0000);
    push_ticks(1);
    // empty clipped areas at the coordinate extremes
    queue_cmd(ACT_FILL, 32767, -32768, 32767, 32767, 0, 32'h5555_5555);
    queue_cmd(ACT_FILL, -32768, 0, -32768, 5, 0, 32'hAAAA_AAAA);
    queue_cmd(ACT_FILL, 0, 0, 5, 0, 0, 32'h1111_1111);
    // frame in the bottom right corner, corners written twice
    queue_cmd(ACT_FRAME, 14, 10, 2, 2, 1, 32'hA5A5_5A5A);
    push_ticks(8);
    // frames with nonpositive thickness or size
    queue_cmd(ACT_FRAME, 0, 0, 4, 4, 0, 32'h2222_2222);
    queue_cmd(ACT_FRAME, 0, 0, -32768, 4, 32767, 32'h3333_3333);
    push_ticks(1);
    settle();
    random_burst(100, 1'b1);
    settle();

    // largest canvas and stride, base just below the wrap point
    program_canvas(1'b1, 32'hFFFF_FFF0, 4095, 4095, 65535);
    random_burst(100, 1'b0);
    settle();

    // receiver idles lightly, sender heavily
    src_idle_pct = 78;
    snk_idle_pct = 36;
    program_canvas(1'b0, 32'h0, 4095, 4095, 640);
    random_burst(40, 1'b1);
    settle();
    program_canvas(1'b1, 32'hFFFF_FFFF, 0, 0, 0);
    random_burst(40, 1'b1);
    settle();

    // random small canvas; write side held off while items keep coming
    program_canvas(1'b1, $urandom, $urandom_range(1, 24), $urandom_range(1, 24),
                   $urandom_range(65535));
    random_burst(130, 1'b1);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    settle();

    // no idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    program_canvas(1'b1, $urandom, 4095, 7, 0);
    random_burst(120, 1'b0);
    settle();
    program_canvas(1'b1, $urandom, 20, 20, $urandom_range(65535));
    random_burst(85, 1'b1);
    // sender pauses here until every write has come back
    settle();
    random_burst(85, 1'b1);
    settle();

    if (fail_count == 0 && owed_writes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
